// ===== hdl/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants for the circular stack ALU
// Operation codes, field widths and reset values used by the core and the
// channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package csa_pkg;

   localparam int unsigned OP_W                = 4;
   localparam int unsigned DATA_W              = 8;
   localparam int unsigned STACK_DEPTH_DEFAULT = 8;

   localparam logic [DATA_W-1:0] SPEED_RESET = 8'd15;

   typedef enum logic [OP_W-1:0] {
      OP_NOP       = 4'd0,
      OP_PUSH      = 4'd1,
      OP_DUP       = 4'd2,
      OP_DROP      = 4'd3,
      OP_BACK      = 4'd4,
      OP_SWAP      = 4'd5,
      OP_OVER      = 4'd6,
      OP_ADD       = 4'd7,
      OP_AND       = 4'd8,
      OP_OR        = 4'd9,
      OP_XOR       = 4'd10,
      OP_INVERT    = 4'd11,
      OP_NEGATE    = 4'd12,
      OP_SET_SPEED = 4'd13
   } op_type;

endpackage

`default_nettype wire

// ===== hdl/csa_if.sv =====
// ----------------------------------------------------------------------------
// csa_if: channel interfaces of the circular stack ALU
// Request channel (operation, push value) and response channel (top,
// second, speed), both valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface csa_req_if import csa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [DATA_W-1:0] push_value;

   modport source (output valid, output operation, output push_value, input ready);
   modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface csa_rsp_if import csa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] top_value;
   logic [DATA_W-1:0] second_value;
   logic [DATA_W-1:0] speed_value;

   modport source (output valid, output top_value, output second_value,
                   output speed_value, input ready);
   modport sink   (input valid, input top_value, input second_value,
                   input speed_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/circular_stack_alu_core.sv =====
// ----------------------------------------------------------------------------
// circular_stack_alu_core: byte data stack in a circular buffer with ALU
// Wrapping top pointer, push/dup/drop/back/swap/over, add/and/or/xor,
// invert, negate and set speed; one response per request.
// ----------------------------------------------------------------------------
// Usage: one request transaction is taken per clock; its response is
// registered and shows up the next cycle, and the next request is taken
// while that response waits as long as the response is being taken in the
// same cycle. The top two slots live in registers, the slots just above
// and below them are kept prefetched in two more registers, and the rest
// of the stack sits in a STACK_DEPTH-entry array written and read once per
// cycle; that single array read sets the cycle time. Slots never written
// read as zero through per-entry valid bits, so there is no clearing pass.
`default_nettype none

module circular_stack_alu_core import csa_pkg::*; #(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   csa_req_if.sink    req_ch,
   csa_rsp_if.source  rsp_ch
);

   localparam int unsigned PTR_W = $clog2(STACK_DEPTH);
   localparam bit          TINY  = (STACK_DEPTH == 2);

   localparam logic [PTR_W:0] DEPTH_V = (PTR_W+1)'(STACK_DEPTH);
   localparam logic [PTR_W:0] OFF_UP1 = (PTR_W+1)'(1 % STACK_DEPTH);
   localparam logic [PTR_W:0] OFF_UP2 = (PTR_W+1)'(2 % STACK_DEPTH);
   localparam logic [PTR_W:0] OFF_DN1 = (PTR_W+1)'(STACK_DEPTH - 1);
   localparam logic [PTR_W:0] OFF_DN3 =
      (PTR_W+1)'((STACK_DEPTH - (3 % STACK_DEPTH)) % STACK_DEPTH);

   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W:0]   k);
      logic [PTR_W:0] s;
      s = {1'b0, p} + k;
      if (s >= DEPTH_V) begin
         s = s - DEPTH_V;
      end
      return s[PTR_W-1:0];
   endfunction

   // state
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [DATA_W-1:0]      top_ff, top_in;
   logic [DATA_W-1:0]      second_ff, second_in;
   logic [DATA_W-1:0]      above_ff;     // slot ptr+1
   logic [DATA_W-1:0]      below_ff;     // slot ptr-2
   logic [DATA_W-1:0]      speed_ff, speed_in;
   logic                   rsp_valid_ff;

   logic [DATA_W-1:0]      mem [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] mem_valid_ff;

   logic                   req_fire;
   logic                   move_up;
   logic                   move_down;
   logic [DATA_W-1:0]      above_val;
   logic [DATA_W-1:0]      below_val;
   logic [PTR_W-1:0]       ptr_up1, ptr_up2, ptr_dn1, ptr_dn3;
   logic                   wr_en;
   logic [PTR_W-1:0]       wr_addr;
   logic [DATA_W-1:0]      wr_data;
   logic [PTR_W-1:0]       rd_addr;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.top_value    = top_ff;
   assign rsp_ch.second_value = second_ff;
   assign rsp_ch.speed_value  = speed_ff;

   assign ptr_up1 = ptr_add(ptr_ff, OFF_UP1);
   assign ptr_up2 = ptr_add(ptr_ff, OFF_UP2);
   assign ptr_dn1 = ptr_add(ptr_ff, OFF_DN1);
   assign ptr_dn3 = ptr_add(ptr_ff, OFF_DN3);

   // with two slots the neighbors outside the window are the window itself
   always_comb begin
      if (TINY) begin
         above_val = second_ff;
         below_val = top_ff;
      end else begin
         above_val = above_ff;
         below_val = below_ff;
      end
   end

   always_comb begin
      move_up   = 1'b0;
      move_down = 1'b0;
      top_in    = top_ff;
      second_in = second_ff;
      speed_in  = speed_ff;
      case (req_ch.operation)
         OP_PUSH: begin
            move_up   = 1'b1;
            top_in    = req_ch.push_value;
            second_in = top_ff;
         end
         OP_DUP: begin
            move_up   = 1'b1;
            second_in = top_ff;
         end
         OP_DROP: begin
            move_down = 1'b1;
            top_in    = second_ff;
            second_in = below_val;
         end
         OP_BACK: begin
            move_up   = 1'b1;
            top_in    = above_val;
            second_in = top_ff;
         end
         OP_SWAP: begin
            top_in    = second_ff;
            second_in = top_ff;
         end
         OP_OVER: begin
            move_up   = 1'b1;
            top_in    = second_ff;
            second_in = top_ff;
         end
         OP_ADD: begin
            move_down = 1'b1;
            top_in    = second_ff + top_ff;
            second_in = below_val;
         end
         OP_AND: begin
            move_down = 1'b1;
            top_in    = second_ff & top_ff;
            second_in = below_val;
         end
         OP_OR: begin
            move_down = 1'b1;
            top_in    = second_ff | top_ff;
            second_in = below_val;
         end
         OP_XOR: begin
            move_down = 1'b1;
            top_in    = second_ff ^ top_ff;
            second_in = below_val;
         end
         OP_INVERT: begin
            top_in = ~top_ff;
         end
         OP_NEGATE: begin
            top_in = ~top_ff + 8'd1;
         end
         OP_SET_SPEED: begin
            move_down = 1'b1;
            speed_in  = top_ff;
            top_in    = second_ff;
            second_in = below_val;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (move_up) begin
         ptr_in = ptr_up1;
      end else if (move_down) begin
         ptr_in = ptr_dn1;
      end else begin
         ptr_in = ptr_ff;
      end
   end

   // slot leaving the register window is written back; the slot that
   // becomes the new outer neighbor is fetched
   assign wr_en   = req_fire && (move_up || move_down);
   assign wr_addr = move_up ? ptr_dn1 : ptr_ff;
   assign wr_data = move_up ? second_ff : top_ff;
   assign rd_addr = move_up ? ptr_up2 : ptr_dn3;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
      end else if (wr_en) begin
         mem_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff <= '0;
         below_ff <= '0;
      end else if (req_fire && move_up) begin
         below_ff <= second_ff;
         if (rd_addr == wr_addr) begin
            above_ff <= wr_data;
         end else if (mem_valid_ff[rd_addr]) begin
            above_ff <= mem[rd_addr];
         end else begin
            above_ff <= '0;
         end
      end else if (req_fire && move_down) begin
         above_ff <= top_ff;
         if (rd_addr == wr_addr) begin
            below_ff <= wr_data;
         end else if (mem_valid_ff[rd_addr]) begin
            below_ff <= mem[rd_addr];
         end else begin
            below_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         top_ff    <= '0;
         second_ff <= '0;
         speed_ff  <= SPEED_RESET;
      end else if (req_fire) begin
         ptr_ff    <= ptr_in;
         top_ff    <= top_in;
         second_ff <= second_in;
         speed_ff  <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

`ifndef SYNTHESIS
   a_push_top: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.operation == OP_PUSH |=> top_ff == $past(req_ch.push_value))
      else $error("push did not land on top");

   a_drop_top: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.operation == OP_DROP |=> top_ff == $past(second_ff))
      else $error("drop did not expose second entry");

   a_speed_set: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.operation == OP_SET_SPEED |=> speed_ff == $past(top_ff))
      else $error("set speed did not take the top entry");

   a_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(ptr_ff) && $stable(top_ff) && $stable(second_ff))
      else $error("stack state moved without a transaction");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");
`endif

endmodule

`default_nettype wire

// ===== bench/circular_stack_alu_core_test.sv =====
// ----------------------------------------------------------------------------
// circular_stack_alu_core_test: self-checking bench for the circular stack ALU
// Runs a directed sweep of every operation and the wrap corners, then random
// request streams under four flow-control phases. A software copy of the
// stack predicts each response, and responses are checked in order.
// ----------------------------------------------------------------------------

module circular_stack_alu_core_test import csa_pkg::*; ();

   localparam int unsigned DEPTH       = STACK_DEPTH_DEFAULT;
   localparam int unsigned PTR_W       = $clog2(DEPTH);
   localparam int          LONG_STALL  = 80;
   localparam int          PHASE_ITEMS = 185;
   localparam int          END_LIMIT   = 2000;

   // codes outside the defined operation set
   localparam logic [OP_W-1:0] OP_UNDEF_LO = 4'd14;
   localparam logic [OP_W-1:0] OP_UNDEF_HI = 4'd15;

   typedef struct packed {
      logic [DATA_W-1:0] top;
      logic [DATA_W-1:0] second;
      logic [DATA_W-1:0] speed;
   } stack_view_type;

   // Shadow stack plus the queue of responses it says should come back.
   class stack_scoreboard;
      bit [DATA_W-1:0] slots [DEPTH];
      bit [PTR_W-1:0]  tos;
      bit [DATA_W-1:0] speed;
      stack_view_type  expected_views [$];
      bit [15:0]       ops_seen;
      int              errors;
      int              requests;
      int              responses;

      function new();
         foreach (slots[i]) slots[i] = '0;
         tos       = '0;
         speed     = SPEED_RESET;
         ops_seen  = '0;
         errors    = 0;
         requests  = 0;
         responses = 0;
      endfunction

      function bit [PTR_W-1:0] slot_up(bit [PTR_W-1:0] p);
         return PTR_W'((p + 1) % DEPTH);
      endfunction

      function bit [PTR_W-1:0] slot_down(bit [PTR_W-1:0] p);
         return PTR_W'((p + DEPTH - 1) % DEPTH);
      endfunction

      function void raise(bit [DATA_W-1:0] v);
         tos        = slot_up(tos);
         slots[tos] = v;
      endfunction

      function bit [DATA_W-1:0] lower();
         bit [DATA_W-1:0] v;
         v   = slots[tos];
         tos = slot_down(tos);
         return v;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
         bit [DATA_W-1:0] a;
         bit [DATA_W-1:0] b;
         stack_view_type  view;
         ops_seen[op] = 1'b1;
         requests++;
         case (op)
            OP_PUSH:      raise(val);
            OP_DUP:       raise(slots[tos]);
            OP_DROP:      void'(lower());
            OP_BACK:      tos = slot_up(tos);
            OP_SWAP: begin
               a = lower();
               b = lower();
               raise(a);
               raise(b);
            end
            OP_OVER: begin
               a = lower();
               b = lower();
               raise(b);
               raise(a);
               raise(b);
            end
            OP_ADD: begin
               a = lower();
               slots[tos] = slots[tos] + a;
            end
            OP_AND: begin
               a = lower();
               slots[tos] = slots[tos] & a;
            end
            OP_OR: begin
               a = lower();
               slots[tos] = slots[tos] | a;
            end
            OP_XOR: begin
               a = lower();
               slots[tos] = slots[tos] ^ a;
            end
            OP_INVERT:    slots[tos] = ~slots[tos];
            OP_NEGATE:    slots[tos] = -slots[tos];
            OP_SET_SPEED: speed = lower();
            default:      ;   // unused codes behave as nop
         endcase
         view.top    = slots[tos];
         view.second = slots[slot_down(tos)];
         view.speed  = speed;
         expected_views.push_back(view);
      endfunction

      function void check_response(logic [DATA_W-1:0] top, logic [DATA_W-1:0] second,
                                   logic [DATA_W-1:0] spd);
         stack_view_type exp_view;
         responses++;
         if (expected_views.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, got top %02h second %02h speed %02h",
                     $time, top, second, spd);
            return;
         end
         exp_view = expected_views.pop_front();
         if (top !== exp_view.top) begin
            errors++;
            $display("%0t: top_value mismatch: expected %02h, got %02h",
                     $time, exp_view.top, top);
         end
         if (second !== exp_view.second) begin
            errors++;
            $display("%0t: second_value mismatch: expected %02h, got %02h",
                     $time, exp_view.second, second);
         end
         if (spd !== exp_view.speed) begin
            errors++;
            $display("%0t: speed_value mismatch: expected %02h, got %02h",
                     $time, exp_view.speed, spd);
         end
      endfunction

      function int pending();
         return expected_views.size();
      endfunction

      function void flag_leftovers();
         if (expected_views.size() != 0) begin
            errors += expected_views.size();
            $display("%0t: %0d responses missing: expected top %02h second %02h speed %02h, got none",
                     $time, expected_views.size(), expected_views[0].top,
                     expected_views[0].second, expected_views[0].speed);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   csa_req_if req_bus ();
   csa_rsp_if rsp_bus ();

   circular_stack_alu_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   stack_scoreboard sb = new();

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int long_stall_asks = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("DONE: errors detected");
      $finish;
   end

   // Transaction monitor: request first so a same-edge response still finds it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.operation, req_bus.push_value);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.top_value, rsp_bus.second_value, rsp_bus.speed_value);
      end
   end

   // Response side backpressure; long holds asked for by the stimulus are served here.
   initial begin : rsp_ready_gen
      int hold_left;
      int served;
      hold_left     = 0;
      served        = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (served != long_stall_asks) begin
            served    = long_stall_asks;
            hold_left = LONG_STALL;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.push_value <= val;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Sender goes quiet until every outstanding response is back or the wait limit runs out.
   task automatic drain_responses();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (sb.pending() != 0 && waited < END_LIMIT);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random();
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] val;
      if ($urandom_range(99) < 30)
         op = OP_PUSH;
      else
         op = OP_W'($urandom_range(15));
      case ($urandom_range(19))
         0:       val = 8'h00;
         1:       val = 8'hFF;
         2:       val = 8'h80;
         3:       val = 8'h7F;
         default: val = DATA_W'($urandom_range(255));
      endcase
      send_request(op, val);
   endtask

   initial begin : stimulus
      int ops_count;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.operation  = OP_NOP;
      req_bus.push_value = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // underflow from reset, then fill past the depth so the pointer wraps
      send_request(OP_DROP,      8'h00);
      send_request(OP_BACK,      8'hFF);
      send_request(OP_SET_SPEED, 8'h00);
      send_request(OP_PUSH,      8'hFF);
      send_request(OP_PUSH,      8'h00);
      send_request(OP_PUSH,      8'h80);
      send_request(OP_PUSH,      8'h7F);
      send_request(OP_PUSH,      8'h01);
      send_request(OP_PUSH,      8'hAA);
      send_request(OP_PUSH,      8'h55);
      send_request(OP_PUSH,      8'h33);
      send_request(OP_PUSH,      8'hCC);
      send_request(OP_DUP,       8'h00);
      send_request(OP_OVER,      8'hFF);
      send_request(OP_SWAP,      8'h00);
      send_request(OP_ADD,       8'hFF);
      send_request(OP_AND,       8'h00);
      send_request(OP_OR,        8'hFF);
      send_request(OP_XOR,       8'h00);
      send_request(OP_INVERT,    8'hFF);
      send_request(OP_NEGATE,    8'h00);
      send_request(OP_SET_SPEED, 8'hFF);
      send_request(OP_NOP,       8'hFF);
      send_request(OP_UNDEF_LO,  8'hFF);
      send_request(OP_UNDEF_HI,  8'h00);
      drain_responses();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold the response side off while requests keep coming
            if ((phase == 0 || phase == 2) && n == PHASE_ITEMS / 2)
               long_stall_asks++;
            send_random();
         end
         drain_responses();
      end

      ops_count = $countones(sb.ops_seen);
      $display("Run covered %0d requests and %0d responses over four flow-control phases",
               sb.requests, sb.responses);
      $display("Operation codes issued: %0d of 16, with long response holds and full drains",
               ops_count);
      sb.flag_leftovers();
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/csa_pkg.sv
hdl/csa_if.sv
hdl/circular_stack_alu_core.sv
bench/circular_stack_alu_core_test.sv
